>>> rtl/pfdr_pkg.sv
// Package for the phase firing delay regulator.
// Holds widths, register indexes, reset values and fixed constants.
// Used by every module of the block; depends on nothing.
package pfdr_pkg;

    // Knob converter resolution actually used (8 to 12 bits).
    localparam int KNOB_BITS   = 10;
    localparam int KNOB_IN_W   = 10;
    localparam int DEADBAND_W  = 10;
    localparam int KCMP_W      = (KNOB_BITS > DEADBAND_W) ? KNOB_BITS : DEADBAND_W;
    localparam int DELAY_W     = 13;
    localparam int PERIOD_W    = 16;
    localparam int COUNT_W     = 8;
    localparam int SCALED_W    = KNOB_BITS + 2;   // knob * 4
    localparam int RECIP_W     = 16;              // width of the 1/3 reciprocal
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam int RECIP_SHIFT = 17;

    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 16;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    typedef logic [KNOB_BITS-1:0] knob_t;
    typedef logic [DELAY_W-1:0]   delay_t;
    typedef logic [PERIOD_W-1:0]  period_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // Register indexes (byte address is 4 * index).
    localparam logic [2:0] REG_RESTART_DELAY    = 3'd0;
    localparam logic [2:0] REG_KNOB_FULL_LEVEL  = 3'd1;
    localparam logic [2:0] REG_FAST_DELAY       = 3'd2;
    localparam logic [2:0] REG_TARGET_PERIOD    = 3'd3;
    localparam logic [2:0] REG_MAINS_LOSS_TICKS = 3'd4;
    localparam logic [2:0] REG_KNOB_DEADBAND    = 3'd5;
    localparam logic [2:0] REG_MIN_DELAY        = 3'd6;

    // Register reset values.
    localparam delay_t               RESTART_DELAY_RST    = 13'd6800;
    localparam logic [9:0]           KNOB_FULL_LEVEL_RST  = 10'd950;
    localparam delay_t               FAST_DELAY_RST       = 13'd4000;
    localparam period_t              TARGET_PERIOD_RST    = 16'd2727;
    localparam count_t               MAINS_LOSS_TICKS_RST = 8'd40;
    localparam logic [DEADBAND_W-1:0] KNOB_DEADBAND_RST   = 10'd50;
    localparam delay_t               MIN_DELAY_RST        = 13'd1000;

    // Fixed constants of the regulation law.
    localparam delay_t  DELAY_RESET      = 13'd7000;
    localparam delay_t  DELAY_MAX        = 13'd8191;
    localparam delay_t  TARGET_BASE      = 13'd5270;
    localparam count_t  STABLE_CAP       = 8'd250;
    localparam period_t AUTO_PERIOD_LOW  = 16'd2200;
    localparam period_t AUTO_PERIOD_HIGH = 16'd4000;
    localparam logic [RECIP_W-1:0] RECIP_THIRD = 16'hAAAB;  // ceil(2^17 / 3)

endpackage

>>> rtl/phase_firing_delay_regulator_unit.sv
// Top level of the phase firing delay regulator: stream in, stream out, APB registers.
// Depends on pfdr_pkg for widths, register indexes and constants.
//
// Path: input register, then result register; a stalled result holds back the flow.
// Throughput: one item per cycle; the state update is one combinational pass.
// Reset: aresetn synchronous, active low; clears valids, state and registers to defaults.
module phase_firing_delay_regulator_unit
    import pfdr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] knob_sample, [10] knob_valid, [11] mains_level,
    // [27:12] period_capture, [28] enable, [31:29] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [12:0] firing_delay, [13] mains_lost, [15:14] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    delay_t                  restart_delay_reg;
    logic [9:0]              knob_full_level_reg;
    delay_t                  fast_delay_reg;
    period_t                 target_period_reg;
    count_t                  mains_loss_ticks_reg;
    logic [DEADBAND_W-1:0]   knob_deadband_reg;
    delay_t                  min_delay_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_delay_reg    <= RESTART_DELAY_RST;
            knob_full_level_reg  <= KNOB_FULL_LEVEL_RST;
            fast_delay_reg       <= FAST_DELAY_RST;
            target_period_reg    <= TARGET_PERIOD_RST;
            mains_loss_ticks_reg <= MAINS_LOSS_TICKS_RST;
            knob_deadband_reg    <= KNOB_DEADBAND_RST;
            min_delay_reg        <= MIN_DELAY_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_RESTART_DELAY:    restart_delay_reg    <= pwdata[DELAY_W-1:0];
                REG_KNOB_FULL_LEVEL:  knob_full_level_reg  <= pwdata[9:0];
                REG_FAST_DELAY:       fast_delay_reg       <= pwdata[DELAY_W-1:0];
                REG_TARGET_PERIOD:    target_period_reg    <= pwdata[PERIOD_W-1:0];
                REG_MAINS_LOSS_TICKS: mains_loss_ticks_reg <= pwdata[COUNT_W-1:0];
                REG_KNOB_DEADBAND:    knob_deadband_reg    <= pwdata[DEADBAND_W-1:0];
                REG_MIN_DELAY:        min_delay_reg        <= pwdata[DELAY_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_RESTART_DELAY:    prdata = APB_DATA_W'(restart_delay_reg);
            REG_KNOB_FULL_LEVEL:  prdata = APB_DATA_W'(knob_full_level_reg);
            REG_FAST_DELAY:       prdata = APB_DATA_W'(fast_delay_reg);
            REG_TARGET_PERIOD:    prdata = APB_DATA_W'(target_period_reg);
            REG_MAINS_LOSS_TICKS: prdata = APB_DATA_W'(mains_loss_ticks_reg);
            REG_KNOB_DEADBAND:    prdata = APB_DATA_W'(knob_deadband_reg);
            REG_MIN_DELAY:        prdata = APB_DATA_W'(min_delay_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds result register. Each stage loads
    // whenever the stage after it is empty or draining, so one item moves per cycle
    // unless the result stalls; a stalled result never blocks a free input stage.
    // ------------------------------------------------------------------
    logic    in_valid_reg;
    logic    out_free;
    logic    advance;

    knob_t   in_knob_reg;
    logic    in_kvalid_reg;
    logic    in_level_reg;
    period_t in_capture_reg;
    logic    in_enable_reg;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Only the low KNOB_BITS bits of the sample take part.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_knob_reg    <= KNOB_BITS'(s_tdata[KNOB_IN_W-1:0]);
            in_kvalid_reg  <= s_tdata[10];
            in_level_reg   <= s_tdata[11];
            in_capture_reg <= s_tdata[27:12];
            in_enable_reg  <= s_tdata[28];
        end
    end

    // ------------------------------------------------------------------
    // Regulator state
    // ------------------------------------------------------------------
    knob_t   knob_value_reg,   knob_value_next;
    period_t speed_period_reg, speed_period_next;
    delay_t  delay_value_reg,  delay_value_next;
    logic    ramp_phase_reg,   ramp_phase_next;
    count_t  stable_count_reg, stable_count_next;
    logic    last_level_reg,   last_level_next;

    // Working signals of the single update pass
    period_t             speed_cap;
    knob_t               knob_diff;
    logic                knob_take;
    logic                mains_loss;
    logic                knob_full;
    logic [SCALED_W-1:0] knob_scaled;
    logic [PROD_W-1:0]   third_prod;
    delay_t              knob_drop;
    delay_t              target;
    logic                auto_band;
    logic                step_down;
    delay_t              step_amt;
    delay_t              delay_reg_upd;

    always_comb begin
        // Capture is stored regardless of enable, but cleared on mains loss while enabled.
        speed_cap = (in_capture_reg != '0) ? in_capture_reg : speed_period_reg;

        // Deadband filter; the first sample after zero is taken as is.
        knob_diff = (in_knob_reg > knob_value_reg) ? (in_knob_reg - knob_value_reg)
                                                   : (knob_value_reg - in_knob_reg);
        knob_take = in_kvalid_reg &&
                    ((knob_value_reg == '0) ||
                     (KCMP_W'(knob_diff) > KCMP_W'(knob_deadband_reg)));
        knob_value_next = knob_take ? in_knob_reg : knob_value_reg;

        // Mains watch: count ticks without a level change, saturating at the cap.
        stable_count_next = stable_count_reg;
        last_level_next   = last_level_reg;
        if (in_enable_reg) begin
            if (in_level_reg == last_level_reg) begin
                if (stable_count_reg < STABLE_CAP) begin
                    stable_count_next = stable_count_reg + count_t'(1);
                end
            end else begin
                stable_count_next = '0;
                last_level_next   = in_level_reg;
            end
        end
        mains_loss = (stable_count_next >= mains_loss_ticks_reg);

        // Target delay: 5270 - knob*4/3 below full level, fast_delay above.
        // knob*4/3 by multiplying with the reciprocal of 3, exact for 16-bit operands.
        knob_full   = KCMP_W'(knob_value_next) > KCMP_W'(knob_full_level_reg);
        knob_scaled = {knob_value_next, 2'b00};
        third_prod  = PROD_W'(knob_scaled) * PROD_W'(RECIP_THIRD);
        knob_drop   = DELAY_W'(third_prod >> RECIP_SHIFT);
        if (knob_full) begin
            target = fast_delay_reg;
        end else if (knob_drop < TARGET_BASE) begin
            target = TARGET_BASE - knob_drop;
        end else begin
            target = '0;
        end

        // Automatic mode band on the (possibly just captured) speed period.
        auto_band = knob_full && (speed_cap > AUTO_PERIOD_LOW) &&
                    (speed_cap < AUTO_PERIOD_HIGH);

        // Soft start ramps by 2, auto trim by 1; steps down act every other tick.
        step_down = (delay_value_reg > target) ||
                    (auto_band && (speed_cap > target_period_reg));
        step_amt  = (delay_value_reg > target) ? delay_t'(2) : delay_t'(1);

        delay_reg_upd   = delay_value_reg;
        ramp_phase_next = ramp_phase_reg;
        if (mains_loss) begin
            delay_reg_upd = restart_delay_reg;
        end else if (step_down) begin
            if (!ramp_phase_reg) begin
                ramp_phase_next = 1'b1;
            end else begin
                delay_reg_upd   = (delay_value_reg > step_amt) ?
                                  (delay_value_reg - step_amt) : '0;
                ramp_phase_next = 1'b0;
            end
        end else if (auto_band) begin
            if (delay_value_reg < DELAY_MAX) begin
                delay_reg_upd = delay_value_reg + delay_t'(1);
            end
        end else begin
            delay_reg_upd = target;
        end

        // Hold everything but capture and knob while disabled.
        if (in_enable_reg) begin
            delay_value_next  = (delay_reg_upd < min_delay_reg) ? min_delay_reg
                                                                : delay_reg_upd;
            speed_period_next = mains_loss ? '0 : speed_cap;
        end else begin
            delay_value_next  = delay_value_reg;
            ramp_phase_next   = ramp_phase_reg;
            speed_period_next = speed_cap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knob_value_reg   <= '0;
            speed_period_reg <= '0;
            delay_value_reg  <= DELAY_RESET;
            ramp_phase_reg   <= 1'b0;
            stable_count_reg <= '0;
            last_level_reg   <= 1'b0;
        end else if (advance) begin
            knob_value_reg   <= knob_value_next;
            speed_period_reg <= speed_period_next;
            delay_value_reg  <= delay_value_next;
            ramp_phase_reg   <= ramp_phase_next;
            stable_count_reg <= stable_count_next;
            last_level_reg   <= last_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    delay_t out_delay_reg;
    logic   out_lost_reg;
    logic   out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_delay_reg <= delay_value_next;
            out_lost_reg  <= mains_loss;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_lost_reg, out_delay_reg};

endmodule

>>> rtl/pfdr_checker.sv
// Port-level checker for the phase firing delay regulator, with its bind.
// Depends on pfdr_pkg for port widths.
module pfdr_checker
    import pfdr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Leave reset with no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // A free result side always lets the input side move.
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while result side is free");

    // Hold a stalled result.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // Pad bits of the result stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:14] == 2'b00))
        else $error("result pad bits set");

endmodule

bind phase_firing_delay_regulator_unit pfdr_checker u_pfdr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
